>>> rtl/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
package tccw_pkg;

   localparam int ROWS_MAX = 32;
   localparam int COLS_MAX = 128;
   localparam int TAB_MAX = 16;
   localparam int COLOUR_MAX = 15;
   localparam int ROW_W = $clog2(ROWS_MAX);
   localparam int COLIX_W = $clog2(COLS_MAX);
   localparam int ADDR_W = ROW_W + COLIX_W;

   localparam logic [3:0] ACT_CHAR = 4'd0;
   localparam logic [3:0] ACT_LEFT = 4'd1;
   localparam logic [3:0] ACT_RIGHT = 4'd2;
   localparam logic [3:0] ACT_UP = 4'd3;
   localparam logic [3:0] ACT_DOWN = 4'd4;
   localparam logic [3:0] ACT_HOME = 4'd5;
   localparam logic [3:0] ACT_LSTART = 4'd6;
   localparam logic [3:0] ACT_DELETE = 4'd7;
   localparam logic [3:0] ACT_ADVANCE = 4'd8;
   localparam logic [3:0] ACT_GOTO = 4'd9;
   localparam logic [3:0] ACT_COLOUR = 4'd10;

   localparam logic [2:0] KIND_CELL = 3'd0;
   localparam logic [2:0] KIND_REFRESH = 3'd1;
   localparam logic [2:0] KIND_SCROLL = 3'd2;
   localparam logic [2:0] KIND_BEEP = 3'd3;
   localparam logic [2:0] KIND_FINAL = 3'd4;

   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_BEL = 8'h07;
   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [2:0] REG_COLS = 3'd0;
   localparam logic [2:0] REG_ROWS = 3'd1;
   localparam logic [2:0] REG_TAB = 3'd2;
   localparam logic [2:0] REG_DFG = 3'd3;
   localparam logic [2:0] REG_DBG = 3'd4;
   localparam logic [2:0] REG_BLANK = 3'd5;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_TABDIV, ST_PUT, ST_LF, ST_SCROLL, ST_FILL,
      ST_CELL, ST_DEL, ST_DEL_RD, ST_DEL_WR, ST_NOTE, ST_FINAL
   } state_type;

endpackage

>>> rtl/text_console_cell_writer_core.sv
// Text console cell writer: sequencer, cursor state and screen memory.
// Plain character: dispatch, put and cell write, then the final cursor word; a new
// word is taken only back in idle. A scrolling line feed adds a scroll word and a fill
// of screen_cols blank cells, a tab repeats the put sequence per cell after a bit-serial
// remainder pass, a delete adds a read and a write per shifted cell. rsp stalls stretch it.
// Reset (synchronous): state, configuration and cursor to defaults, then a memory clear pass.
module text_console_cell_writer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // ch, arg1, arg2, arg1_unused, arg2_unused, zero pad
   input  logic [3:0]  req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // row, col, cell_char, cell_attr, zero pad
   output logic [2:0]  rsp_tuser,  // kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import tccw_pkg::*;

   state_type state_ff, state_in;

   // configuration
   logic [7:0] cfg_cols_ff;
   logic [5:0] cfg_rows_ff;
   logic [4:0] cfg_tab_ff;
   logic [3:0] dfg_ff, dbg_ff;
   logic [7:0] blank_ff;

   // latched word and effective geometry
   logic [3:0] act_ff, act_in;
   logic [7:0] ch_ff, ch_in, a1_ff, a1_in, a2_ff, a2_in;
   logic       a1u_ff, a1u_in, a2u_ff, a2u_in;
   logic [7:0] ecols_ff, ecols_in;
   logic [5:0] erows_ff, erows_in;
   logic [4:0] tab_ff, tab_in;

   // console state
   logic [ROW_W-1:0] row_ff, row_in, top_ff, top_in;
   logic [7:0]       col_ff, col_in;
   logic [3:0]       fg_ff, fg_in, bg_ff, bg_in;

   // sequencer working registers
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [4:0] k_ff, k_in, rem_ff, rem_in;
   logic [2:0] bit_ff, bit_in;
   logic       lfcell_ff, lfcell_in;
   logic [7:0] cnt_ff, cnt_in, pch_ff, pch_in;
   logic [2:0] note_ff, note_in;

   // output register
   logic       ov_ff, ov_in;
   logic [2:0] okind_ff, okind_in;
   logic [4:0] orow_ff, orow_in;
   logic [7:0] ocol_ff, ocol_in, och_ff, och_in, oattr_ff, oattr_in;
   logic       olast_ff, olast_in;

   // screen memory
   logic [15:0] screen_mem [2**ADDR_W];
   logic [15:0] rdq_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [15:0]       mem_wd;

   logic accept, out_free;
   logic [7:0] ecols_c;
   logic [5:0] erows_c;
   logic [4:0] tab_c;
   logic [ROW_W-1:0] line;
   logic [7:0] cur_attr, fill_attr;
   logic [8:0] sum9, lim9, rsum9, rlim9;
   logic [7:0] lmove;
   logic [8:0] rlmove;
   logic [5:0] tsh, tsub;
   logic [7:0] back_col;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free = !ov_ff || rsp_tready;

   assign ecols_c = (cfg_cols_ff == 8'd0) ? 8'd1 :
                    (cfg_cols_ff > 8'(COLS_MAX)) ? 8'(COLS_MAX) : cfg_cols_ff;
   assign erows_c = (cfg_rows_ff == 6'd0) ? 6'd1 :
                    (cfg_rows_ff > 6'(ROWS_MAX)) ? 6'(ROWS_MAX) : cfg_rows_ff;
   assign tab_c   = (cfg_tab_ff == 5'd0) ? 5'd1 :
                    (cfg_tab_ff > 5'(TAB_MAX)) ? 5'(TAB_MAX) : cfg_tab_ff;

   assign line = top_ff + row_ff;
   assign cur_attr = {bg_ff, fg_ff};
   assign fill_attr = {dbg_ff, dfg_ff};

   // cursor move arithmetic
   assign sum9  = {1'b0, col_ff} + {1'b0, a1_ff};
   assign lim9  = {1'b0, ecols_ff} - 9'd1;
   assign lmove = (a1_ff > col_ff) ? 8'd0 : col_ff - a1_ff;
   assign rsum9 = 9'(row_ff) + {1'b0, a1_ff};
   assign rlim9 = 9'(erows_ff) - 9'd1;
   assign rlmove = (a1_ff > 8'(row_ff)) ? 9'd0 : 9'(row_ff) - {1'b0, a1_ff};

   // one restoring remainder step for the tab stop
   assign tsh  = {rem_ff, col_ff[bit_ff]};
   assign tsub = (tsh >= {1'b0, tab_ff}) ? tsh - {1'b0, tab_ff} : tsh;
   assign back_col = sweep_ff[7:0] - cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (sweep_ff == '1) state_in = ST_IDLE;
         ST_IDLE: if (accept) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            state_in = ST_FINAL;
            if (act_ff == ACT_DELETE) state_in = ST_DEL;
            else if (act_ff == ACT_CHAR) begin
               case (ch_ff)
                  CH_LF:  state_in = ST_LF;
                  CH_CR:  state_in = ST_FINAL;
                  CH_BEL: state_in = ST_NOTE;
                  CH_BS:  state_in = ST_DEL;
                  CH_TAB: state_in = ST_TABDIV;
                  default: state_in = ST_PUT;
               endcase
            end
         end
         ST_TABDIV: if (bit_ff == 3'd0) state_in = ST_PUT;
         ST_PUT: state_in = (col_ff >= ecols_ff) ? ST_LF : ST_CELL;
         ST_LF: begin
            if (9'(row_ff) + 9'd1 >= 9'(erows_ff)) state_in = ST_SCROLL;
            else state_in = lfcell_ff ? ST_CELL : ST_FINAL;
         end
         ST_SCROLL: if (out_free) state_in = ST_FILL;
         ST_FILL: begin
            if (sweep_ff[7:0] == ecols_ff - 8'd1) state_in = lfcell_ff ? ST_CELL : ST_FINAL;
         end
         ST_CELL: if (out_free) state_in = (k_ff == 5'd1) ? ST_FINAL : ST_PUT;
         ST_DEL: state_in = (col_ff < cnt_ff) ? ST_NOTE : ST_DEL_RD;
         ST_DEL_RD: state_in = (sweep_ff[7:0] >= ecols_ff) ? ST_NOTE : ST_DEL_WR;
         ST_DEL_WR: state_in = ST_DEL_RD;
         ST_NOTE: if (out_free) state_in = ST_FINAL;
         ST_FINAL: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath, memory port and result word
   always_comb begin
      act_in = act_ff; ch_in = ch_ff; a1_in = a1_ff; a2_in = a2_ff;
      a1u_in = a1u_ff; a2u_in = a2u_ff;
      ecols_in = ecols_ff; erows_in = erows_ff; tab_in = tab_ff;
      row_in = row_ff; col_in = col_ff; top_in = top_ff; fg_in = fg_ff; bg_in = bg_ff;
      sweep_in = sweep_ff; k_in = k_ff; rem_in = rem_ff; bit_in = bit_ff;
      lfcell_in = lfcell_ff; cnt_in = cnt_ff; pch_in = pch_ff; note_in = note_ff;
      ov_in = ov_ff && !rsp_tready;
      okind_in = okind_ff; orow_in = orow_ff; ocol_in = ocol_ff;
      och_in = och_ff; oattr_in = oattr_ff; olast_in = olast_ff;
      mem_we = 1'b0; mem_wa = {line, col_ff[COLIX_W-1:0]}; mem_wd = '0;
      mem_ra = {line, sweep_ff[COLIX_W-1:0]};
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1; mem_wa = sweep_ff; mem_wd = '0;
            sweep_in = sweep_ff + 1'b1;
         end
         ST_IDLE: if (accept) begin
            act_in = req_tuser; ch_in = req_tdata[7:0]; a1_in = req_tdata[15:8];
            a2_in = req_tdata[23:16]; a1u_in = req_tdata[24]; a2u_in = req_tdata[25];
            ecols_in = ecols_c; erows_in = erows_c; tab_in = tab_c;
            // cursor clamp against a shrunk screen
            if ({1'b0, row_ff} >= erows_c) row_in = ROW_W'(erows_c - 6'd1);
            if (col_ff > ecols_c) col_in = ecols_c;
         end
         ST_DISPATCH: begin
            lfcell_in = 1'b0; k_in = 5'd1; pch_in = ch_ff;
            rem_in = '0; bit_in = 3'd7; cnt_in = 8'd1; note_in = KIND_BEEP;
            case (act_ff)
               ACT_CHAR: begin
                  if (ch_ff == CH_CR) col_in = 8'd0;
                  if (ch_ff == CH_TAB) pch_in = CH_SPACE;
               end
               ACT_LEFT: col_in = ({1'b0, lmove} > lim9) ? lim9[7:0] : lmove;
               ACT_RIGHT, ACT_ADVANCE: col_in = (sum9 > lim9) ? lim9[7:0] : sum9[7:0];
               ACT_UP: row_in = (rlmove > rlim9) ? ROW_W'(rlim9) : ROW_W'(rlmove);
               ACT_DOWN: row_in = (rsum9 > rlim9) ? ROW_W'(rlim9) : ROW_W'(rsum9);
               ACT_HOME: begin col_in = 8'd0; row_in = '0; end
               ACT_LSTART: col_in = 8'd0;
               ACT_DELETE: cnt_in = a1_ff;
               ACT_GOTO: begin
                  col_in = (a1_ff < ecols_ff) ? a1_ff : ecols_ff - 8'd1;
                  row_in = (a2_ff < 8'(erows_ff)) ? ROW_W'(a2_ff) : ROW_W'(erows_ff - 6'd1);
               end
               ACT_COLOUR: begin
                  fg_in = a1u_ff ? dfg_ff : (a1_ff > 8'(COLOUR_MAX)) ? 4'(COLOUR_MAX) : a1_ff[3:0];
                  bg_in = a2u_ff ? dbg_ff : (a2_ff > 8'(COLOUR_MAX)) ? 4'(COLOUR_MAX) : a2_ff[3:0];
               end
               default: ;
            endcase
         end
         ST_TABDIV: begin
            rem_in = tsub[4:0];
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) k_in = tab_ff - tsub[4:0];
         end
         ST_PUT: lfcell_in = 1'b1;
         ST_LF: begin
            col_in = 8'd0;
            sweep_in = '0;
            if (9'(row_ff) + 9'd1 >= 9'(erows_ff)) begin
               top_in = top_ff + 1'b1;
               row_in = ROW_W'(erows_ff - 6'd1);
            end else row_in = row_ff + 1'b1;
         end
         ST_SCROLL: if (out_free) begin
            ov_in = 1'b1; okind_in = KIND_SCROLL; orow_in = row_ff; ocol_in = 8'd0;
            och_in = blank_ff; oattr_in = fill_attr; olast_in = 1'b0;
         end
         ST_FILL: begin
            mem_we = 1'b1; mem_wa = {line, sweep_ff[COLIX_W-1:0]};
            mem_wd = {fill_attr, blank_ff};
            sweep_in = sweep_ff + 1'b1;
         end
         ST_CELL: if (out_free) begin
            mem_we = 1'b1; mem_wd = {cur_attr, pch_ff};
            ov_in = 1'b1; okind_in = KIND_CELL; orow_in = row_ff; ocol_in = col_ff;
            och_in = pch_ff; oattr_in = cur_attr; olast_in = 1'b0;
            col_in = col_ff + 8'd1;
            k_in = k_ff - 5'd1;
         end
         ST_DEL: begin
            sweep_in = ADDR_W'(col_ff);
            note_in = (col_ff < cnt_ff) ? KIND_BEEP : KIND_REFRESH;
         end
         ST_DEL_RD: if (sweep_ff[7:0] >= ecols_ff) col_in = col_ff - cnt_ff;
         ST_DEL_WR: begin
            mem_we = 1'b1; mem_wa = {line, back_col[COLIX_W-1:0]}; mem_wd = rdq_ff;
            sweep_in = sweep_ff + 1'b1;
         end
         ST_NOTE: if (out_free) begin
            ov_in = 1'b1; okind_in = note_ff; orow_in = row_ff;
            ocol_in = (note_ff == KIND_BEEP) ? col_ff : 8'd0;
            och_in = 8'd0; oattr_in = 8'd0; olast_in = 1'b0;
         end
         ST_FINAL: if (out_free) begin
            ov_in = 1'b1; okind_in = KIND_FINAL; orow_in = row_ff; ocol_in = col_ff;
            och_in = 8'd0; oattr_in = cur_attr; olast_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sweep_ff <= '0;
         cfg_cols_ff <= 8'd80; cfg_rows_ff <= 6'd25; cfg_tab_ff <= 5'd8;
         dfg_ff <= 4'd7; dbg_ff <= 4'd0; blank_ff <= CH_SPACE;
         row_ff <= '0; col_ff <= '0; top_ff <= '0; fg_ff <= 4'd7; bg_ff <= 4'd0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         row_ff <= row_in; col_ff <= col_in; top_ff <= top_in;
         fg_ff <= fg_in; bg_ff <= bg_in;
         ov_ff <= ov_in;
         if (csr_valid) begin
            case (csr_index)
               REG_COLS:  cfg_cols_ff <= csr_data;
               REG_ROWS:  cfg_rows_ff <= csr_data[5:0];
               REG_TAB:   cfg_tab_ff <= csr_data[4:0];
               REG_DFG:   dfg_ff <= csr_data[3:0];
               REG_DBG:   dbg_ff <= csr_data[3:0];
               REG_BLANK: blank_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in; ch_ff <= ch_in; a1_ff <= a1_in; a2_ff <= a2_in;
      a1u_ff <= a1u_in; a2u_ff <= a2u_in;
      ecols_ff <= ecols_in; erows_ff <= erows_in; tab_ff <= tab_in;
      k_ff <= k_in; rem_ff <= rem_in; bit_ff <= bit_in; lfcell_ff <= lfcell_in;
      cnt_ff <= cnt_in; pch_ff <= pch_in; note_ff <= note_in;
      okind_ff <= okind_in; orow_ff <= orow_in; ocol_ff <= ocol_in;
      och_ff <= och_in; oattr_ff <= oattr_in; olast_ff <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) screen_mem[mem_wa] <= mem_wd;
      rdq_ff <= screen_mem[mem_ra];
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser = okind_ff;
   assign rsp_tlast = olast_ff;
   assign rsp_tdata = {3'd0, oattr_ff, och_ff, ocol_ff, orow_ff};

endmodule

>>> rtl/tccw_checker.sv
// Port-level checks for the console writer, bound to the top level.
module tccw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import tccw_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word accepted during an item");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == KIND_FINAL)))
      else $error("tlast does not match final cursor word");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= KIND_FINAL))
      else $error("bad result kind");

endmodule

bind text_console_cell_writer_core tccw_checker u_tccw_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tuser(rsp_tuser),
   .rsp_tlast(rsp_tlast)
);

>>> test/tb_text_console_cell_writer_core.sv
// Testbench for text_console_cell_writer_core: random and directed items checked by a scoreboard.
`timescale 1ns / 100ps

module tb_text_console_cell_writer_core;
   import tccw_pkg::*;

   // One expected or observed result word
   typedef struct packed {
      logic [2:0] kind;
      logic [4:0] row;
      logic [7:0] col;
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
      logic       last;
   } console_word_type;

   // Tracks cursor, colours and registers; the cell store itself never shows in results
   class console_scoreboard;
      console_word_type pending[$];
      int          mismatches;
      int          words_checked;
      int          cur_row, cur_col;
      logic [3:0]  fg, bg;
      logic [7:0]  reg_cols;
      logic [5:0]  reg_rows;
      logic [4:0]  reg_tab;
      logic [3:0]  reg_dfg, reg_dbg;
      logic [7:0]  reg_blank;
      int          eff_cols, eff_rows, item_words;

      function new();
         reg_cols = 8'd80; reg_rows = 6'd25; reg_tab = 5'd8;
         reg_dfg = 4'd7; reg_dbg = 4'd0; reg_blank = 8'h20;
         cur_row = 0; cur_col = 0; fg = 4'd7; bg = 4'd0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [7:0] val);
         case (idx)
            REG_COLS:  reg_cols = val;
            REG_ROWS:  reg_rows = val[5:0];
            REG_TAB:   reg_tab = val[4:0];
            REG_DFG:   reg_dfg = val[3:0];
            REG_DBG:   reg_dbg = val[3:0];
            REG_BLANK: reg_blank = val;
            default: ;
         endcase
      endfunction

      function void push(logic [2:0] kind, int row, int col, logic [7:0] c,
                         logic [7:0] attr, logic last);
         console_word_type w;
         // at most 32 words ahead of the final cursor word
         if (!last && item_words >= 32) return;
         w.kind = kind; w.row = row[4:0]; w.col = col[7:0];
         w.cell_char = c; w.cell_attr = attr; w.last = last;
         pending.push_back(w);
         item_words++;
      endfunction

      function void line_feed();
         if (cur_row + 1 >= eff_rows) begin
            cur_row = eff_rows - 1;
            push(KIND_SCROLL, cur_row, 0, reg_blank, {reg_dbg, reg_dfg}, 1'b0);
         end else begin
            cur_row++;
         end
         cur_col = 0;
      endfunction

      function void put_cell(logic [7:0] c);
         if (cur_col >= eff_cols) line_feed();
         push(KIND_CELL, cur_row, cur_col, c, {bg, fg}, 1'b0);
         cur_col++;
      endfunction

      function void shift_left(int count);
         if (cur_col < count) begin
            push(KIND_BEEP, cur_row, cur_col, 8'd0, 8'd0, 1'b0);
         end else begin
            cur_col -= count;
            push(KIND_REFRESH, cur_row, 0, 8'd0, 8'd0, 1'b0);
         end
      endfunction

      // Predict every word caused by one accepted input word
      function void note_word(logic [3:0] action, logic [7:0] c, logic [7:0] a1,
                              logic [7:0] a2, logic u1, logic u2);
         int tab, v, n1, n2, rc, rr, rt;
         n1 = int'(a1);
         n2 = int'(a2);
         rc = int'(reg_cols);
         rr = int'(reg_rows);
         rt = int'(reg_tab);
         eff_cols = rc == 0 ? 1 : (rc > COLS_MAX ? COLS_MAX : rc);
         eff_rows = rr == 0 ? 1 : (rr > ROWS_MAX ? ROWS_MAX : rr);
         tab = rt == 0 ? 1 : (rt > TAB_MAX ? TAB_MAX : rt);
         item_words = 0;
         if (cur_row >= eff_rows) cur_row = eff_rows - 1;
         if (cur_col > eff_cols) cur_col = eff_cols;
         case (action)
            ACT_CHAR: begin
               if (c == CH_LF) line_feed();
               else if (c == CH_CR) cur_col = 0;
               else if (c == CH_BEL) push(KIND_BEEP, cur_row, cur_col, 8'd0, 8'd0, 1'b0);
               else if (c == CH_BS) shift_left(1);
               else if (c == CH_TAB) begin
                  for (int k = tab - cur_col % tab; k > 0; k--) put_cell(CH_SPACE);
               end else put_cell(c);
            end
            ACT_LEFT: begin
               v = cur_col - n1;
               cur_col = v < 0 ? 0 : (v > eff_cols - 1 ? eff_cols - 1 : v);
            end
            ACT_RIGHT, ACT_ADVANCE: begin
               v = cur_col + n1;
               cur_col = v > eff_cols - 1 ? eff_cols - 1 : v;
            end
            ACT_UP: begin
               v = cur_row - n1;
               cur_row = v < 0 ? 0 : (v > eff_rows - 1 ? eff_rows - 1 : v);
            end
            ACT_DOWN: begin
               v = cur_row + n1;
               cur_row = v > eff_rows - 1 ? eff_rows - 1 : v;
            end
            ACT_HOME: begin
               cur_col = 0;
               cur_row = 0;
            end
            ACT_LSTART: cur_col = 0;
            ACT_DELETE: shift_left(n1);
            ACT_GOTO: begin
               cur_col = n1 < eff_cols ? n1 : eff_cols - 1;
               cur_row = n2 < eff_rows ? n2 : eff_rows - 1;
            end
            ACT_COLOUR: begin
               fg = u1 ? reg_dfg : (n1 > COLOUR_MAX ? 4'(COLOUR_MAX) : a1[3:0]);
               bg = u2 ? reg_dbg : (n2 > COLOUR_MAX ? 4'(COLOUR_MAX) : a2[3:0]);
            end
            default: ;
         endcase
         push(KIND_FINAL, cur_row, cur_col, 8'd0, {bg, fg}, 1'b1);
      endfunction

      function void check_word(console_word_type got);
         console_word_type exp;
         words_checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result word kind %0d row %0d col %0d",
                        $realtime, got.kind, got.row, got.col);
            return;
         end
         exp = pending.pop_front();
         if (exp !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: mismatch exp kind %0d row %0d col %0d ch %h attr %h last %0d",
                         " / got kind %0d row %0d col %0d ch %h attr %h last %0d"},
                        $realtime, exp.kind, exp.row, exp.col, exp.cell_char,
                        exp.cell_attr, exp.last, got.kind, got.row, got.col,
                        got.cell_char, got.cell_attr, got.last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // ch, arg1, arg2, arg1_unused, arg2_unused, zero pad
   logic [3:0]  req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // row, col, cell_char, cell_attr, zero pad
   logic [2:0]  rsp_tuser;   // kind
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [7:0]  csr_data;

   console_scoreboard board = new();

   int  items_sent;        // input words accepted
   int  idle_cycles;       // watchdog: cycles with no handshake
   bit  quiet;             // no idling on either side near the end
   bit  long_hold_done;
   localparam int STALL_LIMIT = 20000;

   text_console_cell_writer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Monitor: both handshakes are sampled on the pre-edge values
   always @(posedge clock) begin
      console_word_type got;
      if (req_tvalid && req_tready) begin
         board.note_word(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[23:16],
                         req_tdata[24], req_tdata[25]);
         items_sent++;
      end
      if (rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.row = rsp_tdata[4:0];
         got.col = rsp_tdata[12:5];
         got.cell_char = rsp_tdata[20:13];
         got.cell_attr = rsp_tdata[28:21];
         got.last = rsp_tlast;
         board.check_word(got);
      end
   end

   // Watchdog on handshake activity; covers the clear pass after reset too
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("tb_text_console_cell_writer_core: done, errors");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off so the sender backs up
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (!long_hold_done && items_sent >= 120) begin
            long_hold_done = 1;
            rsp_tready <= 1'b0;
            repeat (500) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 17);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 20);
            rsp_tready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   // Valid stays high into the next write; the caller drops it after the last one
   task automatic write_csr(logic [2:0] idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, val);
   endtask

   // Offer one word and hold it until taken; valid stays high into the next word unless a random gap comes first
   task automatic send_word(logic [3:0] action, logic [7:0] c, logic [7:0] a1,
                            logic [7:0] a2, logic u1, logic u2);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= action;
      req_tdata <= {6'd0, u2, u1, a2, a1, c};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Quiet the sender and let the block drain before touching registers
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_screen(logic [7:0] cols, logic [7:0] rows, logic [7:0] tab,
                             logic [7:0] dfg, logic [7:0] dbg, logic [7:0] blank);
      write_csr(REG_COLS, cols);
      write_csr(REG_ROWS, rows);
      write_csr(REG_TAB, tab);
      write_csr(REG_DFG, dfg);
      write_csr(REG_DBG, dbg);
      write_csr(REG_BLANK, blank);
      csr_valid <= 1'b0;
   endtask

   // Random word: text and control bytes, cursor and colour commands, and undefined action codes 11 to 15
   task automatic send_random();
      int sel;
      logic [7:0] c, a1, a2;
      logic u1, u2;
      sel = $urandom_range(0, 99);
      c = 8'($urandom_range(0, 255));
      a1 = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 10));
      a2 = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 34));
      u1 = 1'($urandom_range(0, 1));
      u2 = 1'($urandom_range(0, 1));
      if (sel < 45) begin
         send_word(ACT_CHAR, c, a1, a2, u1, u2);
      end else if (sel < 65) begin
         case ($urandom_range(0, 4))
            0: c = CH_LF;
            1: c = CH_CR;
            2: c = CH_BEL;
            3: c = CH_BS;
            default: c = CH_TAB;
         endcase
         send_word(ACT_CHAR, c, a1, a2, u1, u2);
      end else if (sel < 96) begin
         send_word(4'($urandom_range(1, 10)), c, a1, a2, u1, u2);
      end else begin
         send_word(4'($urandom_range(11, 15)), c, a1, a2, u1, u2);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: defaults after reset, field extremes, each command and control byte
      send_word(ACT_CHAR, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
      send_word(ACT_CHAR, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1);
      send_word(ACT_CHAR, 8'h1b, 8'h00, 8'h00, 1'b0, 1'b0);
      send_word(ACT_CHAR, CH_TAB, 8'h00, 8'h00, 1'b0, 1'b0);
      send_word(ACT_CHAR, CH_BS, 8'h00, 8'h00, 1'b0, 1'b0);
      send_word(ACT_CHAR, CH_BEL, 8'h00, 8'h00, 1'b0, 1'b0);
      send_word(ACT_CHAR, CH_CR, 8'h00, 8'h00, 1'b0, 1'b0);
      send_word(ACT_CHAR, CH_LF, 8'h00, 8'h00, 1'b0, 1'b0);
      send_word(ACT_RIGHT, 8'h00, 8'hff, 8'h00, 1'b0, 1'b0);
      send_word(ACT_LEFT, 8'h00, 8'd3, 8'h00, 1'b0, 1'b0);
      send_word(ACT_ADVANCE, 8'h00, 8'd1, 8'h00, 1'b0, 1'b0);
      send_word(ACT_DELETE, 8'h00, 8'd0, 8'h00, 1'b0, 1'b0);
      send_word(ACT_DELETE, 8'h00, 8'd4, 8'h00, 1'b0, 1'b0);
      send_word(ACT_DELETE, 8'h00, 8'hff, 8'h00, 1'b0, 1'b0);  // count above column
      send_word(ACT_DOWN, 8'h00, 8'hff, 8'h00, 1'b0, 1'b0);
      send_word(ACT_CHAR, CH_LF, 8'h00, 8'h00, 1'b0, 1'b0);     // scroll on bottom row
      send_word(ACT_UP, 8'h00, 8'hff, 8'h00, 1'b0, 1'b0);
      send_word(ACT_GOTO, 8'h00, 8'hff, 8'hff, 1'b0, 1'b0);
      send_word(ACT_LSTART, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
      send_word(ACT_HOME, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
      send_word(ACT_COLOUR, 8'h00, 8'hff, 8'h10, 1'b0, 1'b0);   // saturate both
      send_word(ACT_COLOUR, 8'h00, 8'h03, 8'h05, 1'b1, 1'b0);
      send_word(ACT_COLOUR, 8'h00, 8'h03, 8'h05, 1'b0, 1'b1);
      send_word(4'd11, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
      send_word(4'd15, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);

      // Sender waits out every result before the random part
      drain();

      // Phases: tiny screen, full screen, zero registers, oversized registers, random
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_screen(8'd1, 8'd1, 8'd16, 8'd15, 8'd15, 8'hff);
            1: set_screen(8'd128, 8'd32, 8'd1, 8'd0, 8'd0, 8'h00);
            2: set_screen(8'd0, 8'd0, 8'd0, 8'hf3, 8'hf5, 8'h2e);
            3: set_screen(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h1b);
            default: set_screen(8'($urandom_range(1, 12)), 8'($urandom_range(1, 6)),
                                8'($urandom_range(1, 16)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         if (phase == 5) quiet = 1;
         repeat (73) send_random();
         drain();
      end

      $display("covered %0d input words and %0d result words over 7 register settings",
               items_sent, board.words_checked);
      $display("including tiny, full, zero and oversized screen sizes with stalls");
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("tb_text_console_cell_writer_core: done, clean");
      end else begin
         $display("%0d mismatches, %0d words still expected", board.mismatches,
                  board.pending.size());
         $display("tb_text_console_cell_writer_core: done, errors");
      end
      $finish;
   end

endmodule
